FILE: src/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared constants, register indexes, mode codes and transfer types.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  localparam int unsigned CFG_W  = 9;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 4;

  typedef enum logic [IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_SCALE_MODE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SCALE_PLAIN   = 2'd0,
    SCALE_STRETCH = 2'd1,
    SCALE_FIT     = 2'd2
  } scale_mode_e;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] result_pixel;
    logic             inside_res;
  } out_item_t;

  typedef struct packed {
    logic             is_query;
    logic             dst_ok;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel;
  } q_entry_t;

endpackage

FILE: src/bilinear_image_scaler.sv
// Queries pass the input queue, stages s1 to s4 and the result buffer.
// Throughput: one item per cycle while not stalled by a full queue or a busy divider;
// the four-bank source store serves all neighbours at once. After each register write
// the input stalls while the ratio divider runs one quotient bit per cycle.
// Reset clears control state and sets all sizes to 1 and plain mode; the store is undefined.
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Source store with bilinear scaled read-out of destination pixels.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
  parameter int unsigned MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bis_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bis_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bis_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [bis_pkg::CFG_W-1:0] cfg_data_i
);
  import bis_pkg::*;

  localparam int unsigned SZ_W =
    $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int unsigned RW = SZ_W + FRAC_BITS;
  localparam int unsigned Q_D = 4;

  logic            accept, push, busy, q_full, q_valid, q_pop;
  q_entry_t        entry, q_head;
  logic [$bits(q_entry_t)-1:0] q_vec;
  logic [SZ_W-1:0] sw, sh;
  logic [RW-1:0]   rx, ry;

  assign in_stall_o = q_full || busy;
  assign accept     = in_valid_i && !in_stall_o;

  bis_front #(.MAX_W(MAX_WIDTH), .MAX_H(MAX_HEIGHT), .FRAC(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .push_o      (push),
    .entry_o     (entry),
    .busy_o      (busy),
    .sw_o        (sw),
    .sh_o        (sh),
    .rx_o        (rx),
    .ry_o        (ry)
  );

  bis_fifo #(.WIDTH($bits(q_entry_t)), .DEPTH(Q_D)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_vec),
    .full_o  (q_full)
  );

  assign q_head = q_entry_t'(q_vec);

  bis_back #(.MAX_W(MAX_WIDTH), .MAX_H(MAX_HEIGHT), .FRAC(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .sw_i        (sw),
    .sh_i        (sh),
    .rx_i        (rx),
    .ry_i        (ry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/bis_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bis_fifo.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler queue
// Small first-in first-out buffer in flip-flops.
// ----------------------------------------------------------------------------
module bis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/bis_front.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler front end
// Configuration registers, ratio divider and item classification.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int unsigned MAX_W = 256,
  parameter int unsigned MAX_H = 256,
  parameter int unsigned FRAC  = 16,
  localparam int unsigned SZ_W = $clog2(((MAX_W > MAX_H) ? MAX_W : MAX_H) + 1),
  localparam int unsigned RW   = SZ_W + FRAC
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bis_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [bis_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         accept_i,
  input  bis_pkg::in_item_t            item_i,
  output logic                         push_o,
  output bis_pkg::q_entry_t            entry_o,
  output logic                         busy_o,
  output logic [SZ_W-1:0]              sw_o,
  output logic [SZ_W-1:0]              sh_o,
  output logic [RW-1:0]                rx_o,
  output logic [RW-1:0]                ry_o
);
  import bis_pkg::*;

  localparam int unsigned CW    = (SZ_W > CFG_W) ? SZ_W : CFG_W;
  localparam int unsigned CNT_W = $clog2(RW + 3);
  localparam logic [RW-1:0] ONE = RW'(1) << FRAC;

  logic [CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [1:0]       scale_q;
  logic [SZ_W-1:0]  sw, sh, dw, dh;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RW-1:0]    numx_q, numx_d, numy_q, numy_d;
  logic [RW-1:0]    qx_q, qx_d, qy_q, qy_d;
  logic [SZ_W:0]    remx_q, remx_d, remy_q, remy_d;
  logic [SZ_W:0]    shx, shy;
  logic [RW-1:0]    rx_q, rx_d, ry_q, ry_d;
  logic             cfg_we;

  function automatic logic [SZ_W-1:0] clamp(input logic [CFG_W-1:0] v,
                                            input int unsigned mx);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (v == '0) begin
      return SZ_W'(1);
    end else if (ve > CW'(mx)) begin
      return SZ_W'(mx);
    end
    return SZ_W'(ve);
  endfunction

  assign sw = clamp(src_w_q, MAX_W);
  assign sh = clamp(src_h_q, MAX_H);
  assign dw = clamp(dst_w_q, MAX_W);
  assign dh = clamp(dst_h_q, MAX_H);

  assign cfg_ready_o = (cnt_q == '0);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= CFG_W'(1);
      src_h_q <= CFG_W'(1);
      dst_w_q <= CFG_W'(1);
      dst_h_q <= CFG_W'(1);
      scale_q <= SCALE_PLAIN;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        CFG_SCALE_MODE: scale_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign shx = {remx_q[SZ_W-1:0], numx_q[RW-1]};
  assign shy = {remy_q[SZ_W-1:0], numy_q[RW-1]};

  always_comb begin
    cnt_d  = cnt_q;
    numx_d = numx_q;
    numy_d = numy_q;
    remx_d = remx_q;
    remy_d = remy_q;
    qx_d   = qx_q;
    qy_d   = qy_q;
    rx_d   = rx_q;
    ry_d   = ry_q;
    if (cfg_we) begin
      cnt_d = CNT_W'(RW + 2);
    end else if (cnt_q == CNT_W'(RW + 2)) begin
      numx_d = RW'(sw) << FRAC;
      numy_d = RW'(sh) << FRAC;
      remx_d = '0;
      remy_d = '0;
      cnt_d  = cnt_q - 1'b1;
    end else if (cnt_q > CNT_W'(1)) begin
      numx_d = numx_q << 1;
      numy_d = numy_q << 1;
      if (shx >= {1'b0, dw}) begin
        remx_d = shx - {1'b0, dw};
        qx_d   = {qx_q[RW-2:0], 1'b1};
      end else begin
        remx_d = shx;
        qx_d   = {qx_q[RW-2:0], 1'b0};
      end
      if (shy >= {1'b0, dh}) begin
        remy_d = shy - {1'b0, dh};
        qy_d   = {qy_q[RW-2:0], 1'b1};
      end else begin
        remy_d = shy;
        qy_d   = {qy_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end else if (cnt_q == CNT_W'(1)) begin
      case (scale_mode_e'(scale_q))
        SCALE_PLAIN: begin
          rx_d = ONE;
          ry_d = ONE;
        end
        SCALE_FIT: begin
          rx_d = (qy_q > qx_q) ? qy_q : qx_q;
          ry_d = (qy_q > qx_q) ? qy_q : qx_q;
        end
        default: begin
          rx_d = qx_q;
          ry_d = qy_q;
        end
      endcase
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rx_q  <= ONE;
      ry_q  <= ONE;
    end else begin
      cnt_q <= cnt_d;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    numx_q <= numx_d;
    numy_q <= numy_d;
    remx_q <= remx_d;
    remy_q <= remy_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
  end

  always_comb begin
    entry_o.is_query = (item_i.mode == MODE_QUERY);
    entry_o.dst_ok   = (CW'(item_i.pos_x) < CW'(dw)) && (CW'(item_i.pos_y) < CW'(dh));
    entry_o.pos_x    = item_i.pos_x;
    entry_o.pos_y    = item_i.pos_y;
    entry_o.pixel    = item_i.pixel_value;
    push_o = accept_i && (entry_o.is_query ||
             ((CW'(item_i.pos_x) < CW'(MAX_W)) && (CW'(item_i.pos_y) < CW'(MAX_H))));
  end

  assign sw_o = sw;
  assign sh_o = sh;
  assign rx_o = rx_q;
  assign ry_o = ry_q;

endmodule

FILE: src/bis_back.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler back end
// Coordinate mapping, banked source store, blend pipeline and result buffer.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int unsigned MAX_W = 256,
  parameter int unsigned MAX_H = 256,
  parameter int unsigned FRAC  = 16,
  localparam int unsigned SZ_W = $clog2(((MAX_W > MAX_H) ? MAX_W : MAX_H) + 1),
  localparam int unsigned RW   = SZ_W + FRAC
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  bis_pkg::q_entry_t    q_entry_i,
  output logic                 q_pop_o,
  input  logic [SZ_W-1:0]      sw_i,
  input  logic [SZ_W-1:0]      sh_i,
  input  logic [RW-1:0]        rx_i,
  input  logic [RW-1:0]        ry_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bis_pkg::out_item_t   out_data_o
);
  import bis_pkg::*;

  localparam int unsigned CX_W   = POS_W + RW;
  localparam int unsigned XW     = CX_W - FRAC;
  localparam int unsigned TW     = FRAC + CH_W + 1;
  localparam int unsigned VW     = TW + FRAC + 1;
  localparam int unsigned HALF_W = (MAX_W + 1) / 2;
  localparam int unsigned HALF_H = (MAX_H + 1) / 2;
  localparam int unsigned BANK_D = HALF_W * HALF_H;
  localparam int unsigned BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int unsigned OUT_D  = 8;
  localparam int unsigned CR_W   = $clog2(OUT_D + 1);
  localparam logic [FRAC:0] ONE  = (FRAC + 1)'(1) << FRAC;

  function automatic logic [BA_W-1:0] bank_addr(input logic [XW-1:0] x,
                                                input logic [XW-1:0] y);
    logic [BA_W-1:0] xh, yh;
    xh = BA_W'(x >> 1);
    yh = BA_W'(y >> 1);
    return BA_W'(yh * BA_W'(HALF_W) + xh);
  endfunction

  logic            issue, out_push, out_full, out_pop;
  logic [CR_W-1:0] credit_q, credit_d;

  logic            s1_v_q;
  q_entry_t        s1_q;
  logic            s2_v_q;
  q_entry_t        s2_q;
  logic [CX_W-1:0] cx_q, cy_q;

  logic [XW-1:0]   x0, x1, y0, y1, wx, wy;
  logic [FRAC-1:0] fx, fy;
  logic            inside2;
  logic [BA_W-1:0] raddr [NUM_CH];
  logic            we    [NUM_CH];
  logic [BA_W-1:0] waddr;
  logic [PIX_W-1:0] rdata [NUM_CH];

  logic            s3_v_q, s3_in_q;
  logic [FRAC-1:0] s3_fx_q, s3_fy_q;
  logic            x0p_q, x1p_q, y0p_q, y1p_q;
  logic [PIX_W-1:0] p00, p01, p10, p11;

  logic            s4_v_q, s4_in_q;
  logic [FRAC-1:0] s4_fy_q;
  logic [TW-1:0]   top_q [NUM_CH];
  logic [TW-1:0]   bot_q [NUM_CH];
  logic [PIX_W-1:0] blended;
  out_item_t       res;

  assign issue   = q_valid_i && (!q_entry_i.is_query || (credit_q < CR_W'(OUT_D)));
  assign q_pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      credit_q <= '0;
    end else begin
      s1_v_q   <= issue;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q && s2_q.is_query;
      s4_v_q   <= s3_v_q;
      credit_q <= credit_d;
    end
  end

  assign credit_d = credit_q + CR_W'(issue && q_entry_i.is_query) - CR_W'(out_pop);

  always_ff @(posedge clk_i) begin
    s1_q <= q_entry_i;
    s2_q <= s1_q;
    cx_q <= CX_W'(s1_q.pos_x) * CX_W'(rx_i);
    cy_q <= CX_W'(s1_q.pos_y) * CX_W'(ry_i);
  end

  always_comb begin
    x0 = cx_q[CX_W-1:FRAC];
    y0 = cy_q[CX_W-1:FRAC];
    fx = cx_q[FRAC-1:0];
    fy = cy_q[FRAC-1:0];
    x1 = x0 + XW'(fx != '0);
    y1 = y0 + XW'(fy != '0);
    inside2 = s2_q.dst_ok && (x1 < XW'(sw_i)) && (y1 < XW'(sh_i));
    wx = XW'(s2_q.pos_x);
    wy = XW'(s2_q.pos_y);
    waddr = bank_addr(wx, wy);
  end

  for (genvar b = 0; b < NUM_CH; b++) begin : g_bank
    logic [XW-1:0] bx, by;
    assign bx = (x0[0] == b[0]) ? x0 : x1;
    assign by = (y0[0] == b[1]) ? y0 : y1;
    assign raddr[b] = bank_addr(bx, by);
    assign we[b] = s2_v_q && !s2_q.is_query && ({wy[0], wx[0]} == 2'(b));

    bis_ram #(.WIDTH(PIX_W), .DEPTH(BANK_D)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[b]),
      .waddr_i (waddr),
      .wdata_i (s2_q.pixel),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    s3_in_q <= inside2;
    s3_fx_q <= fx;
    s3_fy_q <= fy;
    x0p_q   <= x0[0];
    x1p_q   <= x1[0];
    y0p_q   <= y0[0];
    y1p_q   <= y1[0];
  end

  assign p00 = rdata[{y0p_q, x0p_q}];
  assign p01 = rdata[{y0p_q, x1p_q}];
  assign p10 = rdata[{y1p_q, x0p_q}];
  assign p11 = rdata[{y1p_q, x1p_q}];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    logic [TW-1:0] omfx, fxe, top_d, bot_d;
    logic [VW-1:0] v;
    assign omfx  = TW'(ONE - (FRAC + 1)'(s3_fx_q));
    assign fxe   = TW'(s3_fx_q);
    assign top_d = TW'(TW'(p00[c*CH_W +: CH_W]) * omfx + TW'(p01[c*CH_W +: CH_W]) * fxe);
    assign bot_d = TW'(TW'(p10[c*CH_W +: CH_W]) * omfx + TW'(p11[c*CH_W +: CH_W]) * fxe);

    always_ff @(posedge clk_i) begin
      top_q[c] <= top_d;
      bot_q[c] <= bot_d;
    end

    assign v = VW'(VW'(top_q[c]) * VW'(ONE - (FRAC + 1)'(s4_fy_q)) +
                   VW'(bot_q[c]) * VW'(s4_fy_q));
    assign blended[c*CH_W +: CH_W] = v[2*FRAC +: CH_W];
  end

  always_ff @(posedge clk_i) begin
    s4_in_q <= s3_in_q;
    s4_fy_q <= s3_fy_q;
  end

  assign res.result_pixel = s4_in_q ? blended : '0;
  assign res.inside_res   = s4_in_q;
  assign out_push         = s4_v_q;
  assign out_pop          = out_valid_o && !out_stall_i;

  logic [$bits(out_item_t)-1:0] out_vec;

  bis_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_D)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .data_o  (out_vec),
    .full_o  (out_full)
  );

  assign out_data_o = out_item_t'(out_vec);

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CR_W'(OUT_D))
    else $error("result credit beyond buffer depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into full buffer");

  a_credit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (credit_q == '0) |-> !out_valid_o && !s4_v_q && !s3_v_q)
    else $error("result present without credit");

endmodule
